### rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and codes for the shell argument tokenizer: parser modes,
// result kinds, byte constants and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

   // parser modes
   localparam logic [2:0] MODE_ARG      = 3'd0;  // inside an unquoted argument
   localparam logic [2:0] MODE_ESC      = 3'd1;  // after an unquoted backslash
   localparam logic [2:0] MODE_ESC_CR   = 3'd2;  // after backslash-CR
   localparam logic [2:0] MODE_QUOTE    = 3'd3;  // inside quotes
   localparam logic [2:0] MODE_QESC     = 3'd4;  // backslash inside double quotes
   localparam logic [2:0] MODE_SKIP     = 3'd5;  // between arguments
   localparam logic [2:0] MODE_SKIP_BS  = 3'd6;  // backslash between arguments
   localparam logic [2:0] MODE_SKIP_BSC = 3'd7;  // backslash-CR between arguments

   // result kinds
   localparam logic [2:0] KIND_BYTE  = 3'd0;
   localparam logic [2:0] KIND_AEND  = 3'd1;
   localparam logic [2:0] KIND_CEND  = 3'd2;
   localparam logic [2:0] KIND_ESC   = 3'd3;
   localparam logic [2:0] KIND_QUOTE = 3'd4;

   // byte constants
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_BTICK  = 8'h60;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;

   // parser state
   typedef struct packed {
      logic [2:0] mode;
      logic       quote_is_double;
      logic [7:0] arg_counter;
   } state_type;

   localparam state_type RESET_STATE = '{mode: MODE_ARG, quote_is_double: 1'b0,
                                         arg_counter: 8'd0};

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] kind;
      logic [7:0] arg_index;
      logic       last;
   } result_type;

   // everything one input byte causes
   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
      state_type  nst;
   } step_type;

endpackage

`default_nettype wire

### rtl/shell_argument_tokenizer_top.sv
// ----------------------------------------------------------------------------
// shell_argument_tokenizer_top
// Splits a zero-terminated command line, one byte per item, into Bourne-style
// arguments and emits argument bytes, argument ends and the command end.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                        | handshake
//  req     | in        | req_in_byte                                  | req_valid / req_stall
//  rsp     | out       | rsp_out_byte rsp_kind rsp_arg_index rsp_last | rsp_valid / rsp_stall
//
//  One byte is accepted per cycle while req_stall is low; its results appear in the result
//  queue the next cycle. Throughput is one item per cycle unless stalled, set by the single
//  parser state update per byte; a byte that yields two results takes an extra output
//  slot, absorbed by the four-entry result queue.
//  req_stall rises while the queue holds three or more results.
//  Reset (synchronous) empties the queue and returns the parser to the
//  unquoted mode with the first argument open.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shell_argument_tokenizer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_arg_index,
   output logic            rsp_last
);

   sat_pkg::state_type  state_ff;
   sat_pkg::step_type   step;
   sat_pkg::result_type queue_ff [4];
   logic [1:0]          wr_ptr_ff;
   logic [1:0]          wr_ptr_in;
   logic [1:0]          rd_ptr_ff;
   logic [1:0]          rd_ptr_in;
   logic [2:0]          count_ff;
   logic [2:0]          count_in;
   logic                push;
   logic                pop;
   logic [1:0]          push_cnt;

   // parser step
   sat_step u_step (
      .st   (state_ff),
      .c    (req_in_byte),
      .step (step)
   );

   // handshake
   assign req_stall = (count_ff > 3'd2);
   assign push      = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign push_cnt  = push ? step.cnt : 2'd0;

   // queue pointers and fill
   assign wr_ptr_in = wr_ptr_ff + push_cnt;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_cnt} - {2'b00, pop};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sat_pkg::RESET_STATE;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (push) begin
            state_ff <= step.nst;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push && (push_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= step.r0;
      end
      if (push && (push_cnt == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= step.r1;
      end
   end

   // result outputs
   assign rsp_out_byte  = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_kind      = queue_ff[rd_ptr_ff].kind;
   assign rsp_arg_index = queue_ff[rd_ptr_ff].arg_index;
   assign rsp_last      = queue_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

### rtl/sat_step.sv
// ----------------------------------------------------------------------------
// sat_step
// Combinational parser step: from the current state and one command byte,
// the next state and up to two result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sat_step (
   input  wire sat_pkg::state_type st,
   input  wire logic [7:0]         c,
   output sat_pkg::step_type       step
);

   function automatic sat_pkg::result_type mk(input logic [2:0] kind, input logic [7:0] b,
                                              input logic [7:0] idx, input logic last);
      sat_pkg::result_type r;
      r.out_byte  = b;
      r.kind      = kind;
      r.arg_index = idx;
      r.last      = last;
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return (b == sat_pkg::CHAR_SPACE) || ((b >= sat_pkg::CHAR_TAB) && (b <= sat_pkg::CHAR_CR));
   endfunction

   function automatic sat_pkg::state_type bump(input sat_pkg::state_type s);
      sat_pkg::state_type t;
      t = s;
      if (s.arg_counter != sat_pkg::COUNT_MAX) begin
         t.arg_counter = s.arg_counter + 8'd1;
      end
      return t;
   endfunction

   // error or command end: one last result and back to reset
   function automatic sat_pkg::step_type fin(input logic [2:0] kind,
                                             input sat_pkg::state_type s);
      sat_pkg::step_type o;
      o.cnt = 2'd1;
      o.r0  = mk(kind, sat_pkg::CHAR_NUL, s.arg_counter, 1'b1);
      o.r1  = '0;
      o.nst = sat_pkg::RESET_STATE;
      return o;
   endfunction

   // byte inside an unquoted argument
   function automatic sat_pkg::step_type arg_fn(input logic [7:0] b,
                                                input sat_pkg::state_type s);
      sat_pkg::step_type o;
      o.cnt      = 2'd0;
      o.r0       = mk(sat_pkg::KIND_BYTE, b, s.arg_counter, 1'b0);
      o.r1       = '0;
      o.nst      = s;
      o.nst.mode = sat_pkg::MODE_ARG;
      if (b == sat_pkg::CHAR_NUL) begin
         o = fin(sat_pkg::KIND_CEND, s);
      end else if (b == sat_pkg::CHAR_SQUOTE || b == sat_pkg::CHAR_DQUOTE) begin
         o.nst.mode            = sat_pkg::MODE_QUOTE;
         o.nst.quote_is_double = (b == sat_pkg::CHAR_DQUOTE);
      end else if (is_ws(b)) begin
         o.cnt      = 2'd1;
         o.r0       = mk(sat_pkg::KIND_AEND, sat_pkg::CHAR_NUL, s.arg_counter, 1'b0);
         o.nst.mode = sat_pkg::MODE_SKIP;
      end else if (b == sat_pkg::CHAR_BSLASH) begin
         o.nst.mode = sat_pkg::MODE_ESC;
      end else begin
         o.cnt = 2'd1;
      end
      return o;
   endfunction

   // byte after an unquoted backslash
   function automatic sat_pkg::step_type esc_fn(input logic [7:0] b,
                                                input sat_pkg::state_type s);
      sat_pkg::step_type o;
      o.cnt = 2'd0;
      o.r0  = mk(sat_pkg::KIND_BYTE, b, s.arg_counter, 1'b0);
      o.r1  = '0;
      o.nst = s;
      if (b == sat_pkg::CHAR_LF) begin
         o.cnt      = 2'd1;
         o.r0       = mk(sat_pkg::KIND_AEND, sat_pkg::CHAR_NUL, s.arg_counter, 1'b0);
         o.nst.mode = sat_pkg::MODE_SKIP;
      end else if (b == sat_pkg::CHAR_CR) begin
         o.nst.mode = sat_pkg::MODE_ESC_CR;
      end else if (b == sat_pkg::CHAR_NUL) begin
         o = fin(sat_pkg::KIND_ESC, s);
      end else begin
         o.cnt      = 2'd1;
         o.nst.mode = sat_pkg::MODE_ARG;
      end
      return o;
   endfunction

   // byte after backslash-CR; a lone CR is kept and the byte parsed again
   function automatic sat_pkg::step_type esc_cr_fn(input logic [7:0] b,
                                                   input sat_pkg::state_type s);
      sat_pkg::step_type o;
      sat_pkg::step_type a;
      a = arg_fn(b, s);
      if (b == sat_pkg::CHAR_LF) begin
         o.cnt      = 2'd1;
         o.r0       = mk(sat_pkg::KIND_AEND, sat_pkg::CHAR_NUL, s.arg_counter, 1'b0);
         o.r1       = '0;
         o.nst      = s;
         o.nst.mode = sat_pkg::MODE_SKIP;
      end else begin
         o.cnt = a.cnt + 2'd1;
         o.r0  = mk(sat_pkg::KIND_BYTE, sat_pkg::CHAR_CR, s.arg_counter, 1'b0);
         o.r1  = a.r0;
         o.nst = a.nst;
      end
      return o;
   endfunction

   logic [7:0] close_quote;
   logic       keep_bslash;

   assign close_quote = st.quote_is_double ? sat_pkg::CHAR_DQUOTE : sat_pkg::CHAR_SQUOTE;
   assign keep_bslash = (c != sat_pkg::CHAR_BSLASH) && (c != sat_pkg::CHAR_DQUOTE) &&
                        (c != sat_pkg::CHAR_BTICK) && (c != sat_pkg::CHAR_DOLLAR) &&
                        (c != sat_pkg::CHAR_LF);

   // mode dispatch
   always_comb begin
      step.cnt = 2'd0;
      step.r0  = mk(sat_pkg::KIND_BYTE, c, st.arg_counter, 1'b0);
      step.r1  = '0;
      step.nst = st;
      case (st.mode)
         sat_pkg::MODE_ARG: begin
            step = arg_fn(c, st);
         end
         sat_pkg::MODE_ESC: begin
            step = esc_fn(c, st);
         end
         sat_pkg::MODE_ESC_CR: begin
            step = esc_cr_fn(c, st);
         end
         sat_pkg::MODE_QUOTE: begin
            if (c == sat_pkg::CHAR_NUL) begin
               step = fin(sat_pkg::KIND_CEND, st);
            end else if (c == close_quote) begin
               step.nst.mode = sat_pkg::MODE_ARG;
            end else if (c == sat_pkg::CHAR_BSLASH && st.quote_is_double) begin
               step.nst.mode = sat_pkg::MODE_QESC;
            end else begin
               step.cnt = 2'd1;
            end
         end
         sat_pkg::MODE_QESC: begin
            if (c == sat_pkg::CHAR_NUL) begin
               step = fin(sat_pkg::KIND_QUOTE, st);
            end else begin
               step.nst.mode = sat_pkg::MODE_QUOTE;
               if (keep_bslash) begin
                  step.cnt = 2'd2;
                  step.r0  = mk(sat_pkg::KIND_BYTE, sat_pkg::CHAR_BSLASH, st.arg_counter, 1'b0);
                  step.r1  = mk(sat_pkg::KIND_BYTE, c, st.arg_counter, 1'b0);
               end else begin
                  step.cnt = 2'd1;
               end
            end
         end
         sat_pkg::MODE_SKIP: begin
            if (c == sat_pkg::CHAR_NUL) begin
               step = fin(sat_pkg::KIND_CEND, st);
            end else if (is_ws(c)) begin
               step.nst = st;
            end else if (c == sat_pkg::CHAR_BSLASH) begin
               step.nst.mode = sat_pkg::MODE_SKIP_BS;
            end else begin
               step = arg_fn(c, bump(st));
            end
         end
         sat_pkg::MODE_SKIP_BS: begin
            if (c == sat_pkg::CHAR_LF) begin
               step.nst.mode = sat_pkg::MODE_SKIP;
            end else if (c == sat_pkg::CHAR_CR) begin
               step.nst.mode = sat_pkg::MODE_SKIP_BSC;
            end else begin
               step = esc_fn(c, bump(st));
            end
         end
         sat_pkg::MODE_SKIP_BSC: begin
            if (c == sat_pkg::CHAR_LF) begin
               step.nst.mode = sat_pkg::MODE_SKIP;
            end else begin
               step = esc_cr_fn(c, bump(st));
            end
         end
         default: begin
            step = arg_fn(c, sat_pkg::RESET_STATE);
         end
      endcase
   end

endmodule

`default_nettype wire
